// ===== rtl/core/rae_pkg.sv =====
// ----------------------------------------------------------------------------
// rae_pkg: shared types and constants of the register execute core
// Request and response payloads, the decoded command word that travels from
// the front end to the execute pipeline, and the operation codes.
// ----------------------------------------------------------------------------
package rae_pkg;

  localparam int unsigned OPC_W     = 6;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned IMM_W     = 16;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned CMDQ_DEPTH = 2;

  localparam logic [OPC_W-1:0] OPC_ADD  = 6'd0;
  localparam logic [OPC_W-1:0] OPC_ADDI = 6'd1;
  localparam logic [OPC_W-1:0] OPC_SUB  = 6'd2;
  localparam logic [OPC_W-1:0] OPC_SUBI = 6'd3;
  localparam logic [OPC_W-1:0] OPC_MUL  = 6'd4;
  localparam logic [OPC_W-1:0] OPC_MULI = 6'd5;
  localparam logic [OPC_W-1:0] OPC_OR   = 6'd6;
  localparam logic [OPC_W-1:0] OPC_ORI  = 6'd7;
  localparam logic [OPC_W-1:0] OPC_AND  = 6'd8;
  localparam logic [OPC_W-1:0] OPC_ANDI = 6'd9;
  localparam logic [OPC_W-1:0] OPC_XOR  = 6'd10;
  localparam logic [OPC_W-1:0] OPC_XORI = 6'd11;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_OR,
    ALU_AND,
    ALU_XOR
  } alu_op_e;

  typedef struct packed {
    logic [OPC_W-1:0]        opcode;
    logic [IDX_W-1:0]        src_reg;
    logic [IDX_W-1:0]        second_reg;
    logic [IDX_W-1:0]        dest_reg;
    logic signed [IMM_W-1:0] immediate;
  } rae_req_t;

  typedef struct packed {
    logic                    wrote;
    logic [IDX_W-1:0]        written_index;
    logic signed [OUT_W-1:0] written_value;
  } rae_rsp_t;

  typedef struct packed {
    logic                    wr_en;
    logic                    use_imm;
    alu_op_e                 op;
    logic [IDX_W-1:0]        rs;
    logic [IDX_W-1:0]        rt;
    logic [IDX_W-1:0]        dst;
    logic signed [IMM_W-1:0] imm;
  } rae_cmd_t;

endpackage

// ===== rtl/core/rae_front.sv =====
// ----------------------------------------------------------------------------
// rae_front: request decoder
// Classifies each request into an ALU operation, operand sources and a
// destination, and hands the decoded command to the command queue.
// ----------------------------------------------------------------------------
module rae_front #(
  parameter int unsigned RegCount = 32
) (
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  rae_pkg::rae_req_t req_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output rae_pkg::rae_cmd_t cmd_o
);

  logic                          known;
  rae_pkg::alu_op_e              op;
  logic [rae_pkg::IDX_W-1:0]     dst;

  always_comb begin
    known = 1'b1;
    op    = rae_pkg::ALU_ADD;
    unique case (req_i.opcode)
      rae_pkg::OPC_ADD, rae_pkg::OPC_ADDI: op = rae_pkg::ALU_ADD;
      rae_pkg::OPC_SUB, rae_pkg::OPC_SUBI: op = rae_pkg::ALU_SUB;
      rae_pkg::OPC_MUL, rae_pkg::OPC_MULI: op = rae_pkg::ALU_MUL;
      rae_pkg::OPC_OR,  rae_pkg::OPC_ORI:  op = rae_pkg::ALU_OR;
      rae_pkg::OPC_AND, rae_pkg::OPC_ANDI: op = rae_pkg::ALU_AND;
      rae_pkg::OPC_XOR, rae_pkg::OPC_XORI: op = rae_pkg::ALU_XOR;
      default: known = 1'b0;
    endcase

    if (!known) begin
      dst = '0;
    end else if (req_i.opcode[0]) begin
      dst = req_i.second_reg;
    end else begin
      dst = req_i.dest_reg;
    end

    cmd_o.wr_en   = known && (32'(dst) < RegCount);
    cmd_o.use_imm = req_i.opcode[0];
    cmd_o.op      = op;
    cmd_o.rs      = req_i.src_reg;
    cmd_o.rt      = req_i.second_reg;
    cmd_o.dst     = dst;
    cmd_o.imm     = req_i.immediate;
  end

  assign cmd_valid_o = req_valid_i;
  assign req_ready_o = cmd_ready_i;

endmodule

// ===== rtl/core/rae_fifo.sv =====
// ----------------------------------------------------------------------------
// rae_fifo: command queue
// Short queue of decoded commands between the decoder and the execute
// pipeline, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module rae_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rae_pkg::rae_cmd_t in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rae_pkg::rae_cmd_t out_o
);

  localparam int unsigned PtrW = $clog2(rae_pkg::CMDQ_DEPTH);
  localparam int unsigned CntW = $clog2(rae_pkg::CMDQ_DEPTH + 1);

  rae_pkg::rae_cmd_t entry_q [rae_pkg::CMDQ_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push, pop;

  assign in_ready_o  = (count_q != CntW'(rae_pkg::CMDQ_DEPTH));
  assign out_valid_o = (count_q != '0);
  assign out_o       = entry_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(rae_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(rae_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_i;
    end
  end

endmodule

// ===== rtl/core/rae_back.sv =====
// ----------------------------------------------------------------------------
// rae_back: execute pipeline with register file
// Reads operands from the register file, executes the ALU operation over
// two stages, writes the result back and presents it in an output register.
// ----------------------------------------------------------------------------
module rae_back #(
  parameter int unsigned RegCount = 32,
  parameter int unsigned DataW    = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  rae_pkg::rae_cmd_t cmd_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output rae_pkg::rae_rsp_t rsp_o
);

  localparam int unsigned AddrW = $clog2(RegCount);

  logic [DataW-1:0]          rf_mem [RegCount];
  logic                      vld_q [RegCount];

  logic                      adv, hazard, pop;
  logic [AddrW-1:0]          rd_addr_a, rd_addr_b, wr_addr;
  logic                      rd_ok_a, rd_ok_b;
  logic [DataW-1:0]          rdata_a_q, rdata_b_q;
  logic                      ok_a_q, ok_b_q;

  logic                      s2_valid_q;
  rae_pkg::rae_cmd_t         s2_cmd_q;
  logic [DataW-1:0]          op_a, op_b;
  logic [DataW-1:0]          alu_d, alu_q;

  logic                      s3_valid_q;
  rae_pkg::rae_cmd_t         s3_cmd_q;
  logic [DataW-1:0]          mul_res;
  logic signed [DataW-1:0]   s3_res;
  logic                      wr_fire;

  logic                      wb_valid_q;
  logic [rae_pkg::IDX_W-1:0] wb_idx_q;
  logic [DataW-1:0]          wb_data_q;

  logic                      rsp_valid_q;
  rae_pkg::rae_rsp_t         rsp_q, rsp_d;

  assign adv = !rsp_valid_q || rsp_ready_i;

  // The item in the execute stage writes too late for a read issued now.
  assign hazard = s2_valid_q && s2_cmd_q.wr_en &&
                  ((s2_cmd_q.dst == cmd_i.rs) ||
                   (!cmd_i.use_imm && (s2_cmd_q.dst == cmd_i.rt)));

  assign cmd_ready_o = adv && !hazard;
  assign pop         = cmd_valid_i && cmd_ready_o;

  assign rd_addr_a = AddrW'(cmd_i.rs);
  assign rd_addr_b = AddrW'(cmd_i.rt);
  assign rd_ok_a   = (32'(cmd_i.rs) < RegCount) && vld_q[rd_addr_a];
  assign rd_ok_b   = (32'(cmd_i.rt) < RegCount) && vld_q[rd_addr_b];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rdata_a_q <= rf_mem[rd_addr_a];
      rdata_b_q <= rf_mem[rd_addr_b];
      ok_a_q    <= rd_ok_a;
      ok_b_q    <= rd_ok_b;
    end
  end

  always_comb begin
    if (wb_valid_q && (wb_idx_q == s2_cmd_q.rs)) begin
      op_a = wb_data_q;
    end else begin
      op_a = ok_a_q ? rdata_a_q : '0;
    end

    if (s2_cmd_q.use_imm) begin
      op_b = DataW'(signed'(s2_cmd_q.imm));
    end else if (wb_valid_q && (wb_idx_q == s2_cmd_q.rt)) begin
      op_b = wb_data_q;
    end else begin
      op_b = ok_b_q ? rdata_b_q : '0;
    end

    unique case (s2_cmd_q.op)
      rae_pkg::ALU_ADD: alu_d = op_a + op_b;
      rae_pkg::ALU_SUB: alu_d = op_a - op_b;
      rae_pkg::ALU_OR:  alu_d = op_a | op_b;
      rae_pkg::ALU_AND: alu_d = op_a & op_b;
      rae_pkg::ALU_XOR: alu_d = op_a ^ op_b;
      default:          alu_d = '0;
    endcase
  end

  if (DataW <= 32) begin : g_mul_narrow
    logic [DataW-1:0] prod_d, prod_q;

    assign prod_d = op_a * op_b;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        prod_q <= prod_d;
      end
    end

    assign mul_res = prod_q;
  end else begin : g_mul_wide
    // Low and cross partial products; the cross terms only feed the upper half.
    localparam int unsigned HiW = DataW - 32;

    logic [63:0]      lo_d;
    logic [DataW-1:0] lo_q;
    logic [HiW-1:0]   cross1_d, cross1_q, cross2_d, cross2_q;

    assign lo_d     = {32'b0, op_a[31:0]} * {32'b0, op_b[31:0]};
    assign cross1_d = op_a[DataW-1:32] * op_b[HiW-1:0];
    assign cross2_d = op_a[HiW-1:0] * op_b[DataW-1:32];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        lo_q     <= lo_d[DataW-1:0];
        cross1_q <= cross1_d;
        cross2_q <= cross2_d;
      end
    end

    assign mul_res = lo_q + {HiW'(cross1_q + cross2_q), 32'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      wb_valid_q  <= 1'b0;
    end else if (adv) begin
      s2_valid_q  <= pop;
      s3_valid_q  <= s2_valid_q;
      rsp_valid_q <= s3_valid_q;
      wb_valid_q  <= wr_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_cmd_q <= cmd_i;
      s3_cmd_q <= s2_cmd_q;
      alu_q    <= alu_d;
      rsp_q    <= rsp_d;
    end
  end

  assign s3_res  = (s3_cmd_q.op == rae_pkg::ALU_MUL) ? mul_res : alu_q;
  assign wr_fire = adv && s3_valid_q && s3_cmd_q.wr_en;
  assign wr_addr = AddrW'(s3_cmd_q.dst);

  always_comb begin
    rsp_d.wrote         = s3_cmd_q.wr_en;
    rsp_d.written_index = s3_cmd_q.dst;
    rsp_d.written_value = s3_cmd_q.wr_en ? rae_pkg::OUT_W'(s3_res) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      rf_mem[wr_addr] <= s3_res;
      wb_idx_q        <= s3_cmd_q.dst;
      wb_data_q       <= s3_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(RegCount); i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (wr_fire) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== rtl/core/risc_alu_register_execute_core.sv =====
// ----------------------------------------------------------------------------
// risc_alu_register_execute_core: ALU execute stage with register file
// Executes one decoded add, subtract, multiply, or, and or xor request per
// cycle when not stalled, against a register file that reads as zero after
// reset. Register forms write dest_reg, immediate forms write second_reg with
// the immediate sign extended, and unknown opcodes write nothing. Requests are
// accepted at one per cycle while the queue has room; a request that reads the
// register written by the request directly ahead of it waits at the head of
// the queue until that write can be forwarded, since the register file read
// is registered. When nothing stalls, a request passes through the queue, the
// operand read register and the execute register, after which write back and
// the output register are loaded at the same edge.
// ----------------------------------------------------------------------------
module risc_alu_register_execute_core #(
  parameter int unsigned REG_COUNT  = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  rae_pkg::rae_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output rae_pkg::rae_rsp_t rsp_o
);

  logic              dec_valid, dec_ready;
  rae_pkg::rae_cmd_t dec_cmd;
  logic              q_valid, q_ready;
  rae_pkg::rae_cmd_t q_cmd;

  rae_front #(
    .RegCount (REG_COUNT)
  ) u_front (
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .cmd_valid_o (dec_valid),
    .cmd_ready_i (dec_ready),
    .cmd_o       (dec_cmd)
  );

  rae_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dec_valid),
    .in_ready_o  (dec_ready),
    .in_i        (dec_cmd),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_o       (q_cmd)
  );

  rae_back #(
    .RegCount (REG_COUNT),
    .DataW    (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== test/risc_alu_register_execute_core_tb.sv =====
// ----------------------------------------------------------------------------
// risc_alu_register_execute_core_tb: self-checking bench for the ALU execute core
// Runs directed and random requests through the core under varying idle
// patterns on both ports. A scoreboard keeps its own register file and
// predicts the written value of every accepted request. Responses are
// checked in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module risc_alu_register_execute_core_tb;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned RANDOM_PER_PHASE = 550;

  class alu_writeback_scoreboard;
    logic [rae_pkg::OUT_W-1:0] regs [32];
    rae_pkg::rae_rsp_t         expected_writes [$];
    int unsigned               errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      errors = 0;
    endfunction

    function rae_pkg::rae_rsp_t retire(rae_pkg::rae_req_t r);
      logic [rae_pkg::OUT_W-1:0] a;
      logic [rae_pkg::OUT_W-1:0] b;
      logic [rae_pkg::OUT_W-1:0] res;
      logic [rae_pkg::IDX_W-1:0] dst;
      rae_pkg::rae_rsp_t         rsp;
      rsp = '0;
      if (r.opcode > rae_pkg::OPC_XORI) return rsp;
      a = regs[r.src_reg];
      if (r.opcode[0]) begin
        b   = {{(rae_pkg::OUT_W-rae_pkg::IMM_W){r.immediate[rae_pkg::IMM_W-1]}}, r.immediate};
        dst = r.second_reg;
      end else begin
        b   = regs[r.second_reg];
        dst = r.dest_reg;
      end
      case (r.opcode)
        rae_pkg::OPC_ADD, rae_pkg::OPC_ADDI: res = a + b;
        rae_pkg::OPC_SUB, rae_pkg::OPC_SUBI: res = a - b;
        rae_pkg::OPC_MUL, rae_pkg::OPC_MULI: res = a * b;
        rae_pkg::OPC_OR,  rae_pkg::OPC_ORI:  res = a | b;
        rae_pkg::OPC_AND, rae_pkg::OPC_ANDI: res = a & b;
        default:                             res = a ^ b;
      endcase
      regs[dst]         = res;
      rsp.wrote         = 1'b1;
      rsp.written_index = dst;
      rsp.written_value = res;
      return rsp;
    endfunction

    function void note_request(rae_pkg::rae_req_t r);
      expected_writes.push_back(retire(r));
    endfunction

    function void check_response(rae_pkg::rae_rsp_t got);
      rae_pkg::rae_rsp_t want;
      if (expected_writes.size() == 0) begin
        $display("%0t: response with nothing expected, got %h", $time, got);
        errors++;
        return;
      end
      want = expected_writes.pop_front();
      if (got.wrote !== want.wrote) begin
        $display("%0t: wrote expected %0d got %0d", $time, want.wrote, got.wrote);
        errors++;
      end
      if (got.written_index !== want.written_index) begin
        $display("%0t: written_index expected %0d got %0d", $time,
                 want.written_index, got.written_index);
        errors++;
      end
      if (got.written_value !== want.written_value) begin
        $display("%0t: written_value expected %h got %h", $time,
                 want.written_value, got.written_value);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              req_valid_i;
  logic              req_ready_o;
  rae_pkg::rae_req_t req_i;
  logic              rsp_valid_o;
  logic              rsp_ready_i;
  rae_pkg::rae_rsp_t rsp_o;

  int unsigned send_idle_pct;
  int unsigned rsp_idle_pct;
  int unsigned rsp_hold;

  alu_writeback_scoreboard board;

  risc_alu_register_execute_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    for (int unsigned n = 0; n < CYCLE_LIMIT; n++) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  // The receiver counts out a forced hold itself, otherwise it stalls at random.
  initial begin
    rsp_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_hold > 0) begin
        rsp_hold--;
        rsp_ready_i <= 1'b0;
      end else begin
        rsp_ready_i <= ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rsp_valid_o && rsp_ready_i) board.check_response(rsp_o);
  end

  function automatic rae_pkg::rae_req_t make_req(logic [rae_pkg::OPC_W-1:0] opc,
                                                 int unsigned rs, int unsigned rt,
                                                 int unsigned rd, int imm);
    rae_pkg::rae_req_t r;
    r.opcode     = opc;
    r.src_reg    = rs[rae_pkg::IDX_W-1:0];
    r.second_reg = rt[rae_pkg::IDX_W-1:0];
    r.dest_reg   = rd[rae_pkg::IDX_W-1:0];
    r.immediate  = imm[rae_pkg::IMM_W-1:0];
    return r;
  endfunction

  task automatic send_request(rae_pkg::rae_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    do @(posedge clk_i); while (!req_ready_o);
    board.note_request(r);
  endtask

  task automatic wait_for_results();
    req_valid_i <= 1'b0;
    while (board.expected_writes.size() > 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    rae_pkg::rae_req_t         r;
    logic [rae_pkg::IDX_W-1:0] last_dst;
    int                        imm;
    board         = new();
    send_idle_pct = 21;
    rsp_idle_pct  = 69;
    rsp_hold      = 0;
    last_dst      = '0;
    rst_ni        <= 1'b0;
    req_valid_i   <= 1'b0;
    req_i         <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Build large operands first so the wrapping cases below have work to do.
    send_request(make_req(rae_pkg::OPC_ADDI, 0, 1, 0, 32767));
    send_request(make_req(rae_pkg::OPC_ADDI, 0, 2, 31, -32768));
    send_request(make_req(rae_pkg::OPC_SUBI, 0, 3, 0, -32768));
    send_request(make_req(rae_pkg::OPC_MULI, 1, 4, 0, 32767));
    send_request(make_req(rae_pkg::OPC_MUL, 4, 4, 5, 0));
    send_request(make_req(rae_pkg::OPC_ADD, 4, 4, 6, -1));
    send_request(make_req(rae_pkg::OPC_ADD, 6, 6, 7, 0));
    send_request(make_req(rae_pkg::OPC_SUB, 2, 6, 8, 0));
    send_request(make_req(rae_pkg::OPC_OR, 1, 2, 9, 0));
    send_request(make_req(rae_pkg::OPC_ORI, 4, 10, 0, -1));
    send_request(make_req(rae_pkg::OPC_AND, 7, 5, 11, 0));
    send_request(make_req(rae_pkg::OPC_ANDI, 10, 12, 0, 16'h5555));
    send_request(make_req(rae_pkg::OPC_XOR, 7, 10, 13, 0));
    send_request(make_req(rae_pkg::OPC_XORI, 13, 14, 0, -32768));
    send_request(make_req(6'd12, 7, 8, 9, 1234));
    send_request(make_req(6'd63, 31, 31, 31, -1));
    send_request(make_req(rae_pkg::OPC_ADDI, 0, 0, 0, 5));
    send_request(make_req(rae_pkg::OPC_ADD, 0, 0, 0, 0));
    send_request(make_req(rae_pkg::OPC_SUBI, 31, 31, 0, 1));
    send_request(make_req(rae_pkg::OPC_SUB, 31, 0, 31, 0));
    send_request(make_req(rae_pkg::OPC_MULI, 7, 30, 0, -1));
    send_request(make_req(rae_pkg::OPC_XORI, 1, 1, 31, 32767));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 21;
          rsp_idle_pct  = 69;
        end
        1: begin
          send_idle_pct = 69;
          rsp_idle_pct  = 21;
        end
        default: begin
          send_idle_pct = 0;
          rsp_idle_pct  = 0;
        end
      endcase
      for (int unsigned i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (phase == 0 && i == 200) rsp_hold = 150;
        if (phase == 1 && i == 300) wait_for_results();
        if (phase == 2 && i == 100) rsp_hold = 80;
        if ($urandom_range(99) < 90) r.opcode = 6'($urandom_range(11));
        else r.opcode = 6'($urandom_range(63, 12));
        r.src_reg    = 5'($urandom_range(31));
        r.second_reg = 5'($urandom_range(31));
        r.dest_reg   = 5'($urandom_range(31));
        case ($urandom_range(9))
          0: imm = 0;
          1: imm = -1;
          2: imm = 32767;
          3: imm = -32768;
          default: imm = int'($urandom_range(65535));
        endcase
        r.immediate = imm[rae_pkg::IMM_W-1:0];
        // Lean on back-to-back dependencies to stress the read-after-write path.
        if ($urandom_range(99) < 40) r.src_reg = last_dst;
        if ($urandom_range(99) < 25) r.second_reg = last_dst;
        send_request(r);
        if (r.opcode <= rae_pkg::OPC_XORI) begin
          last_dst = r.opcode[0] ? r.second_reg : r.dest_reg;
        end
      end
    end

    wait_for_results();
    repeat (10) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
